>>> design/lfcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcq_pkg
// shared types and constants of the loop filter coefficient quantizer
// ----------------------------------------------------------------------------
package lfcq_pkg;

   localparam int COEF_W        = 64;
   localparam int EXP_FIELD_W   = 11;
   localparam int FRAC_FIELD_W  = 52;
   localparam int EXP_BIAS      = 1023;

   localparam int LANE_MANT_W   = 17;
   localparam int ALPHA_MANT_W  = 16;
   localparam int BG_MANT_W     = 17;
   localparam int DELTA_MANT_W  = 15;

   localparam int ALPHA_FRAC    = 16;
   localparam int BG_FRAC       = 17;
   localparam int DELTA_FRAC    = 15;

   localparam int ALPHA_DOWN_W  = 6;
   localparam int SIMPLE_EXP_W  = 5;
   localparam int ALPHA_DOWN_MAX = 63;
   localparam int SIMPLE_EXP_MAX = 31;
   localparam int ALPHA_UP_MAX  = 22;
   localparam int UP_LO_MAX     = 7;
   localparam int UP_HI_MAX     = 15;
   localparam int SHIFT_LIMIT   = 60;

   typedef enum logic [1:0] {
      LANE_SHIFT,
      LANE_ONE,
      LANE_MAX
   } lane_op_type;

   typedef struct packed {
      logic [LANE_MANT_W-1:0]  mant;
      logic [ALPHA_DOWN_W-1:0] down;
      logic [2:0]              up_lo;
      logic [3:0]              up_hi;
      logic                    bad;
   } lane_res_type;

endpackage
`default_nettype wire

>>> design/lfcq_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcq_lane
// converts one double word into a mantissa and exponents, two stages
// ----------------------------------------------------------------------------
module lfcq_lane
   import lfcq_pkg::*;
#(
   parameter int MANT_W   = 17,
   parameter int FRAC     = 17,
   parameter int DOWN_MAX = 31,
   parameter bit IS_ALPHA = 1'b0,
   parameter bit POSITIVE = 1'b0
) (
   input  wire logic              clock,
   input  wire logic [COEF_W-1:0] coef,
   output lane_res_type          res
);

   localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

   logic [EXP_FIELD_W-1:0]  exp_field;
   logic [FRAC_FIELD_W-1:0] frac_field;
   logic                    sgn, frac_nz, is_nan, is_inf, is_tiny, is_zero, is_bad;
   logic                    below_one, above_one, use_down;
   logic [12:0]             exp_val, c_val, neg_c, sh, nsh;
   logic [5:0]              down;
   logic [4:0]              up;
   lane_op_type             op;
   logic [5:0]              down_out;
   logic [2:0]              lo_out;
   logic [3:0]              hi_out;

   lane_op_type             op_ff;
   logic [52:0]             m_ff;
   logic [5:0]              n_ff, down_ff;
   logic [2:0]              lo_ff;
   logic [3:0]              hi_ff;
   logic                    bad_ff;
   lane_res_type            res_ff, res_in;

   logic [63:0]             m_ext;
   logic [52:0]             shifted;
   logic [53:0]             sum;
   logic [MANT_W-1:0]       mant;

   always_comb begin
      sgn        = coef[63];
      exp_field  = coef[62:52];
      frac_field = coef[51:0];
      frac_nz    = (frac_field != '0);
      is_nan     = (exp_field == '1) && frac_nz;
      is_inf     = (exp_field == '1) && !frac_nz;
      is_tiny    = (exp_field == '0);
      is_zero    = is_tiny && !frac_nz;
      is_bad     = is_nan || (POSITIVE && (sgn || is_zero));
      below_one  = (exp_field < 11'(EXP_BIAS));
      above_one  = (exp_field > 11'(EXP_BIAS)) || ((exp_field == 11'(EXP_BIAS)) && frac_nz);
      exp_val    = {2'b00, exp_field};
      c_val      = exp_val - 13'(EXP_BIAS) + {12'b0, frac_nz};
      neg_c      = 13'd0 - c_val;
      use_down   = IS_ALPHA ? below_one : 1'b1;
      down       = '0;
      if (use_down) begin
         if ($signed(neg_c) > $signed(13'(DOWN_MAX))) begin
            down = 6'(DOWN_MAX);
         end else if ($signed(neg_c) > 13'sd0) begin
            down = neg_c[5:0];
         end
      end
      up = '0;
      if (IS_ALPHA && above_one) begin
         up = ($signed(c_val) > $signed(13'(ALPHA_UP_MAX))) ? 5'(ALPHA_UP_MAX) : c_val[4:0];
      end
      sh  = exp_val - 13'(EXP_BIAS + FRAC_FIELD_W) + 13'(FRAC) + {7'b0, down} - {8'b0, up};
      nsh = 13'd0 - sh;

      op       = LANE_SHIFT;
      down_out = down;
      lo_out   = (up > 5'(UP_LO_MAX)) ? 3'(UP_LO_MAX) : up[2:0];
      hi_out   = 4'(up - {2'b00, lo_out});
      if (is_bad) begin
         op       = LANE_ONE;
         down_out = '0;
         lo_out   = '0;
         hi_out   = '0;
      end else if (is_inf) begin
         op       = LANE_MAX;
         down_out = '0;
         lo_out   = IS_ALPHA ? 3'(UP_LO_MAX) : 3'd0;
         hi_out   = IS_ALPHA ? 4'(UP_HI_MAX) : 4'd0;
      end else if (is_tiny) begin
         op       = LANE_ONE;
         down_out = 6'(DOWN_MAX);
         lo_out   = '0;
         hi_out   = '0;
      end else if (!sh[12]) begin
         op = LANE_MAX;
      end else if ($signed(nsh) > $signed(13'(SHIFT_LIMIT))) begin
         op = LANE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op;
      m_ff    <= {1'b1, frac_field};
      n_ff    <= nsh[5:0];
      down_ff <= down_out;
      lo_ff   <= lo_out;
      hi_ff   <= hi_out;
      bad_ff  <= is_bad;
   end

   // rounding half away from zero, then saturation
   always_comb begin
      m_ext   = {11'b0, m_ff};
      shifted = m_ff >> n_ff;
      sum     = {1'b0, shifted} + {53'b0, m_ext[n_ff - 6'd1]};
      mant    = MANT_W'(1);
      case (op_ff)
         LANE_SHIFT: begin
            if (sum == '0) begin
               mant = MANT_W'(1);
            end else if (sum > 54'(MANT_MAX)) begin
               mant = MANT_MAX;
            end else begin
               mant = sum[MANT_W-1:0];
            end
         end
         LANE_MAX: mant = MANT_MAX;
         LANE_ONE: mant = MANT_W'(1);
         default:  mant = MANT_W'(1);
      endcase
      res_in.mant  = LANE_MANT_W'(mant);
      res_in.down  = down_ff;
      res_in.up_lo = lo_ff;
      res_in.up_hi = hi_ff;
      res_in.bad   = bad_ff;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule
`default_nettype wire

>>> design/lfcq_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfcq_merge
// combines the four lane results into one registered result word
// ----------------------------------------------------------------------------
module lfcq_merge
   import lfcq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          lane_valid,
   input  lane_res_type       alpha_res,
   input  lane_res_type       beta_res,
   input  lane_res_type       gamma_res,
   input  lane_res_type       delta_res,
   output logic               rsp_valid,
   output logic [15:0]        rsp_alpha_mantissa,
   output logic [5:0]         rsp_alpha_down_exp,
   output logic [2:0]         rsp_alpha_up_exp_low,
   output logic [3:0]         rsp_alpha_up_exp_high,
   output logic [16:0]        rsp_beta_mantissa,
   output logic [4:0]         rsp_beta_exp,
   output logic [16:0]        rsp_gamma_mantissa,
   output logic [4:0]         rsp_gamma_exp,
   output logic [14:0]        rsp_delta_mantissa,
   output logic [4:0]         rsp_delta_exp,
   output logic               rsp_bad_input
);

   logic valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lane_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alpha_mantissa    <= alpha_res.mant[ALPHA_MANT_W-1:0];
      rsp_alpha_down_exp    <= alpha_res.down;
      rsp_alpha_up_exp_low  <= alpha_res.up_lo;
      rsp_alpha_up_exp_high <= alpha_res.up_hi;
      rsp_beta_mantissa     <= beta_res.mant[BG_MANT_W-1:0];
      rsp_beta_exp          <= beta_res.down[SIMPLE_EXP_W-1:0];
      rsp_gamma_mantissa    <= gamma_res.mant[BG_MANT_W-1:0];
      rsp_gamma_exp         <= gamma_res.down[SIMPLE_EXP_W-1:0];
      rsp_delta_mantissa    <= delta_res.mant[DELTA_MANT_W-1:0];
      rsp_delta_exp         <= delta_res.down[SIMPLE_EXP_W-1:0];
      rsp_bad_input         <= alpha_res.bad | beta_res.bad | gamma_res.bad | delta_res.bad;
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

>>> design/loop_filter_coef_quantizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// loop_filter_coef_quantizer_top
// quantizes four double coefficients into mantissa/exponent fields
// ----------------------------------------------------------------------------
// A word is taken on every clock edge with start high; busy is always low.
// Each word gives one result on the rsp_ ports, marked by rsp_valid for one
// cycle; the result passes the decode stage and the shift and round stage
// in each of the four lanes, then the merge register. The receiver cannot
// stall, so results leave at the same one word per cycle rate.
// ----------------------------------------------------------------------------
module loop_filter_coef_quantizer_top
   import lfcq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_alpha_coef,
   input  wire logic [63:0] req_beta_coef,
   input  wire logic [63:0] req_gamma_coef,
   input  wire logic [63:0] req_delta_coef,
   output logic             rsp_valid,
   output logic [15:0]      rsp_alpha_mantissa,
   output logic [5:0]       rsp_alpha_down_exp,
   output logic [2:0]       rsp_alpha_up_exp_low,
   output logic [3:0]       rsp_alpha_up_exp_high,
   output logic [16:0]      rsp_beta_mantissa,
   output logic [4:0]       rsp_beta_exp,
   output logic [16:0]      rsp_gamma_mantissa,
   output logic [4:0]       rsp_gamma_exp,
   output logic [14:0]      rsp_delta_mantissa,
   output logic [4:0]       rsp_delta_exp,
   output logic             rsp_bad_input
);

   logic         accept;
   logic         v1_ff, v2_ff;
   lane_res_type alpha_res, beta_res, gamma_res, delta_res;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   lfcq_lane #(
      .MANT_W(ALPHA_MANT_W), .FRAC(ALPHA_FRAC), .DOWN_MAX(ALPHA_DOWN_MAX),
      .IS_ALPHA(1'b1), .POSITIVE(1'b1)
   ) u_alpha (.clock(clock), .coef(req_alpha_coef), .res(alpha_res));

   lfcq_lane #(
      .MANT_W(BG_MANT_W), .FRAC(BG_FRAC), .DOWN_MAX(SIMPLE_EXP_MAX),
      .IS_ALPHA(1'b0), .POSITIVE(1'b0)
   ) u_beta (.clock(clock), .coef(req_beta_coef), .res(beta_res));

   lfcq_lane #(
      .MANT_W(BG_MANT_W), .FRAC(BG_FRAC), .DOWN_MAX(SIMPLE_EXP_MAX),
      .IS_ALPHA(1'b0), .POSITIVE(1'b0)
   ) u_gamma (.clock(clock), .coef(req_gamma_coef), .res(gamma_res));

   lfcq_lane #(
      .MANT_W(DELTA_MANT_W), .FRAC(DELTA_FRAC), .DOWN_MAX(SIMPLE_EXP_MAX),
      .IS_ALPHA(1'b0), .POSITIVE(1'b1)
   ) u_delta (.clock(clock), .coef(req_delta_coef), .res(delta_res));

   lfcq_merge u_merge (
      .clock                (clock),
      .reset                (reset),
      .lane_valid           (v2_ff),
      .alpha_res            (alpha_res),
      .beta_res             (beta_res),
      .gamma_res            (gamma_res),
      .delta_res            (delta_res),
      .rsp_valid            (rsp_valid),
      .rsp_alpha_mantissa   (rsp_alpha_mantissa),
      .rsp_alpha_down_exp   (rsp_alpha_down_exp),
      .rsp_alpha_up_exp_low (rsp_alpha_up_exp_low),
      .rsp_alpha_up_exp_high(rsp_alpha_up_exp_high),
      .rsp_beta_mantissa    (rsp_beta_mantissa),
      .rsp_beta_exp         (rsp_beta_exp),
      .rsp_gamma_mantissa   (rsp_gamma_mantissa),
      .rsp_gamma_exp        (rsp_gamma_exp),
      .rsp_delta_mantissa   (rsp_delta_mantissa),
      .rsp_delta_exp        (rsp_delta_exp),
      .rsp_bad_input        (rsp_bad_input)
   );

   // a result word only follows a taken word
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a taken word");

   a_mant_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_mantissa != 16'd0) && (rsp_beta_mantissa != 17'd0)
                    && (rsp_gamma_mantissa != 17'd0) && (rsp_delta_mantissa != 15'd0))
      else $error("zero mantissa");

   a_alpha_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alpha_down_exp != 6'd0)
         |-> (rsp_alpha_up_exp_low == 3'd0) && (rsp_alpha_up_exp_high == 4'd0))
      else $error("alpha shifted both ways");

   a_alpha_split: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_alpha_up_exp_high != 4'd0) |-> (rsp_alpha_up_exp_low == 3'd7))
      else $error("alpha up exponent split wrong");

endmodule
`default_nettype wire
